// ===== hw/rtl/bfie_pkg.sv =====
//------------------------------------------------------------------------------
// Bloom filter insert engine package
// Shared request and response types, operation and status codes, and
// mixing constants.
//------------------------------------------------------------------------------
`default_nettype none

package bfie_pkg;

  // Operation codes carried in the func field.
  localparam logic [1:0] FUNC_INSERT = 2'd0;
  localparam logic [1:0] FUNC_READ   = 2'd1;
  localparam logic [1:0] FUNC_CLEAR  = 2'd2;

  // Status codes of a response.
  localparam logic [1:0] STAT_INSERTED = 2'd0;
  localparam logic [1:0] STAT_SKIPPED  = 2'd1;
  localparam logic [1:0] STAT_CLEARED  = 2'd2;
  localparam logic [1:0] STAT_READ     = 2'd3;

  // Configuration register indexes.
  localparam logic [0:0] CFG_SIZE   = 1'b0;
  localparam logic [0:0] CFG_HASHES = 1'b1;

  // Mixing constants, default hash count and minimum filter size.
  localparam logic [63:0] MIX_C1     = 64'hff51afd7ed558ccd;
  localparam logic [63:0] MIX_C2     = 64'hc4ceb9fe1a85ec53;
  localparam logic [63:0] GOLDEN     = 64'h9e3779b97f4a7c15;
  localparam logic [63:0] BUCKET_MUL = 64'h517cc1b727220a95;
  localparam logic [3:0]  DEFAULT_HASHES = 4'd3;
  localparam logic [16:0] MIN_BITS   = 17'd64;

  typedef struct packed {
    logic [1:0]  func;
    logic [63:0] key_hash;
    logic [63:0] time_bucket;
    logic        also_previous;
    logic [9:0]  read_index;
  } req_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [9:0]  word_index;
    logic [63:0] word_value;
  } rsp_t;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_INIT,
    ST_CLEAR,
    ST_READ,
    ST_READ_WAIT,
    ST_BUCKET_A,
    ST_BUCKET_B,
    ST_GOLD_A,
    ST_GOLD_B,
    ST_MIX1_A,
    ST_MIX1_B,
    ST_MIX2_A,
    ST_MIX2_B,
    ST_MOD_START,
    ST_MOD,
    ST_RMW_RD,
    ST_RMW_WR,
    ST_RESP
  } state_t;

  // Control from the sequencer to the multiply unit.
  typedef struct packed {
    logic        load;
    logic        upper;
    logic [63:0] a;
    logic [63:0] b;
  } mul_ctl_t;

endpackage

`default_nettype wire

// ===== hw/rtl/bloom_filter_insert_engine.sv =====
//------------------------------------------------------------------------------
// Bloom filter insert engine
// Sets k hashed bit positions per insert in a word store, and clears or reads it.
//------------------------------------------------------------------------------
// Channel   | Signals                                   | Handshake
// request   | start, busy, req                          | taken when start && !busy
// response  | rsp_valid, rsp                            | one-cycle strobe, no stall
// config    | cfg_valid, cfg_ready, cfg_index, cfg_data | taken when cfg_valid && cfg_ready
//
// An insert runs a bucket product and, per hash position, six steps on the
// two-step shared multiplier, one to start the modulo unit, its bit-serial
// loop and a read-modify-write. A previous bucket repeats the pass. The
// response state follows the last write. A skipped zero hash goes straight to
// it, a read passes a read and a wait state, a clear sweeps STORE_WORDS words.
// After reset a clearing pass over all STORE_WORDS words runs while busy is high.
// The response cannot be stalled; busy drops in the cycle it is shown.
//------------------------------------------------------------------------------
`default_nettype none

module bloom_filter_insert_engine #(
  parameter int STORE_WORDS = 1024,
  parameter int MAX_HASHES  = 8
) (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           start,
  output logic                busy,
  input  wire bfie_pkg::req_t req,
  output logic                rsp_valid,
  output bfie_pkg::rsp_t      rsp,
  input  wire logic           cfg_valid,
  output logic                cfg_ready,
  input  wire logic           cfg_index,
  input  wire logic [31:0]    cfg_data
);
  import bfie_pkg::*;

  localparam int AW = (STORE_WORDS > 1) ? $clog2(STORE_WORDS) : 1;
  // The size register cannot exceed 17 bits, so the cap is limited to that.
  localparam int CAP_INT = (STORE_WORDS * 64 > 131071) ? 131071 : STORE_WORDS * 64;
  localparam logic [16:0] CAP_BITS = 17'(CAP_INT);
  localparam logic [4:0]  MAXH = 5'(MAX_HASHES);

  state_t state, state_next;

  logic [16:0] size_reg;
  logic [3:0]  hash_reg;
  logic [16:0] eff_bits;
  logic [4:0]  eff_hash;

  req_t        cur;
  logic [63:0] bucket;
  logic [63:0] bmix;
  logic [4:0]  kidx;
  logic        second;
  logic        last_hash;
  logic [AW:0] clr_addr;
  logic [16:0] pos;
  logic [10:0] pos_word;
  logic [63:0] mix_in;
  logic [63:0] mix_fold;
  logic [63:0] prod_fold;

  logic [63:0] mem [STORE_WORDS];
  logic [63:0] rd_data;
  logic        mem_we;
  logic [AW-1:0] mem_waddr;
  logic [63:0] mem_wdata;
  logic [AW-1:0] mem_raddr;

  mul_ctl_t    mctl;
  logic [63:0] mprod;
  logic        mod_start, mod_done;
  logic [16:0] mod_rem;

  // Effective size and hash count after clamping.
  always_comb begin
    eff_bits = size_reg;
    if (eff_bits < MIN_BITS) eff_bits = MIN_BITS;
    if (eff_bits > CAP_BITS) eff_bits = CAP_BITS;
    eff_hash = (hash_reg == 4'd0) ? {1'b0, DEFAULT_HASHES} : {1'b0, hash_reg};
    if (eff_hash > MAXH) eff_hash = MAXH;
  end

  // Configuration registers, taken only while idle.
  assign cfg_ready = (state == ST_IDLE);
  always_ff @(posedge clk) begin
    if (rst) begin
      size_reg <= 17'd65536;
      hash_reg <= 4'd3;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_SIZE:   size_reg <= cfg_data[16:0];
        CFG_HASHES: hash_reg <= cfg_data[3:0];
        default:    ;
      endcase
    end
  end

  // Mix input and the xor-shift folds of the finalizer.
  assign mix_in    = cur.key_hash ^ bmix ^ mprod;
  assign mix_fold  = mix_in ^ {33'd0, mix_in[63:33]};
  assign prod_fold = mprod ^ {33'd0, mprod[63:33]};

  bfie_mul u_mul (
    .clk  (clk),
    .ctl  (mctl),
    .prod (mprod)
  );

  bfie_mod u_mod (
    .clk       (clk),
    .rst       (rst),
    .start     (mod_start),
    .dividend  (prod_fold),
    .divisor   (eff_bits),
    .done      (mod_done),
    .remainder (mod_rem)
  );

  // Word store with one write and one registered read port.
  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_waddr] <= mem_wdata;
    rd_data <= mem[mem_raddr];
  end

  assign pos       = mod_rem;
  assign pos_word  = pos[16:6];
  assign last_hash = (kidx + 5'd1 >= eff_hash);

  // Sequencer state register.
  always_ff @(posedge clk) begin
    if (rst) state <= ST_INIT;
    else     state <= state_next;
  end

  assign busy = (state != ST_IDLE);

  // Next state, multiplier control and store control.
  always_comb begin
    state_next = state;
    mctl       = '0;
    mod_start  = 1'b0;
    mem_we     = 1'b0;
    mem_waddr  = clr_addr[AW-1:0];
    mem_wdata  = '0;
    mem_raddr  = (cur.func == FUNC_INSERT) ? AW'(pos_word) : AW'(cur.read_index);
    unique case (state)
      ST_IDLE: begin
        mem_raddr = AW'(req.read_index);
        if (start) begin
          unique case (req.func)
            FUNC_INSERT: state_next = (req.key_hash == 64'd0) ? ST_RESP : ST_BUCKET_A;
            FUNC_CLEAR:  state_next = ST_CLEAR;
            default:     state_next = ST_READ;
          endcase
        end
      end
      ST_INIT: begin
        mem_we = 1'b1;
        if (clr_addr == (AW+1)'(STORE_WORDS - 1)) state_next = ST_IDLE;
      end
      ST_CLEAR: begin
        mem_we = 1'b1;
        if (clr_addr == (AW+1)'(STORE_WORDS - 1)) state_next = ST_RESP;
      end
      ST_READ:      state_next = ST_READ_WAIT;
      ST_READ_WAIT: state_next = ST_RESP;
      ST_BUCKET_A: begin
        mctl.load = 1'b1;
        mctl.a = bucket;
        mctl.b = BUCKET_MUL;
        state_next = ST_BUCKET_B;
      end
      ST_BUCKET_B: begin
        mctl.upper = 1'b1;
        state_next = ST_GOLD_A;
      end
      ST_GOLD_A: begin
        mctl.load = 1'b1;
        mctl.a = {59'd0, kidx} + 64'd1;
        mctl.b = GOLDEN;
        state_next = ST_GOLD_B;
      end
      ST_GOLD_B: begin
        mctl.upper = 1'b1;
        state_next = ST_MIX1_A;
      end
      ST_MIX1_A: begin
        mctl.load = 1'b1;
        mctl.a = mix_fold;
        mctl.b = MIX_C1;
        state_next = ST_MIX1_B;
      end
      ST_MIX1_B: begin
        mctl.upper = 1'b1;
        state_next = ST_MIX2_A;
      end
      ST_MIX2_A: begin
        mctl.load = 1'b1;
        mctl.a = prod_fold;
        mctl.b = MIX_C2;
        state_next = ST_MIX2_B;
      end
      ST_MIX2_B: begin
        mctl.upper = 1'b1;
        state_next = ST_MOD_START;
      end
      ST_MOD_START: begin
        mod_start  = 1'b1;
        state_next = ST_MOD;
      end
      ST_MOD: begin
        if (mod_done) state_next = ST_RMW_RD;
      end
      ST_RMW_RD: state_next = ST_RMW_WR;
      ST_RMW_WR: begin
        mem_we    = ({21'd0, pos_word} < 32'(STORE_WORDS));
        mem_waddr = AW'(pos_word);
        mem_wdata = rd_data | (64'd1 << pos[5:0]);
        if (!last_hash) begin
          state_next = ST_GOLD_A;
        end else if (!second && cur.also_previous && cur.time_bucket != 64'd0) begin
          state_next = ST_BUCKET_A;
        end else begin
          state_next = ST_RESP;
        end
      end
      ST_RESP:  state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  // Datapath registers for the current request.
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_addr <= '0;
      kidx     <= '0;
      second   <= 1'b0;
    end else begin
      unique case (state)
        ST_IDLE: begin
          clr_addr <= '0;
          kidx     <= '0;
          second   <= 1'b0;
          if (start) begin
            cur    <= req;
            bucket <= req.time_bucket;
          end
        end
        ST_INIT:  clr_addr <= clr_addr + (AW+1)'(1);
        ST_CLEAR: clr_addr <= clr_addr + (AW+1)'(1);
        // The bucket product is ready at the first hash of each bucket.
        ST_GOLD_A: begin
          if (kidx == 5'd0) bmix <= mprod;
        end
        ST_RMW_WR: begin
          if (!last_hash) begin
            kidx <= kidx + 5'd1;
          end else begin
            kidx   <= '0;
            second <= 1'b1;
            bucket <= cur.time_bucket - 64'd1;
          end
        end
        default: ;
      endcase
    end
  end

  // Response register.
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else begin
      rsp_valid <= (state == ST_RESP);
    end
    if (state == ST_RESP) begin
      rsp.word_index <= '0;
      rsp.word_value <= '0;
      if (cur.func == FUNC_INSERT) begin
        rsp.status <= (cur.key_hash == 64'd0) ? STAT_SKIPPED : STAT_INSERTED;
      end else if (cur.func == FUNC_CLEAR) begin
        rsp.status <= STAT_CLEARED;
      end else begin
        rsp.status     <= STAT_READ;
        rsp.word_index <= cur.read_index;
        rsp.word_value <= ({22'd0, cur.read_index} < 32'(STORE_WORDS)) ? rd_data : 64'd0;
      end
    end
  end

  a_busy_after_start: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy) else $error("busy did not rise after start");
  a_single_rsp: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |=> !rsp_valid) else $error("response strobe longer than one cycle");
  a_cfg_idle: assert property (@(posedge clk) disable iff (rst)
    cfg_ready |-> !busy) else $error("config accepted while busy");

endmodule

`default_nettype wire

// ===== hw/rtl/bfie_mul.sv =====
//------------------------------------------------------------------------------
// Bloom filter shared multiplier
// Produces the low 64 bits of a 64x64 product in two steps: the low 32x32
// partial product on load, then the cross terms, registered between steps.
//------------------------------------------------------------------------------
`default_nettype none

module bfie_mul (
  input  wire logic              clk,
  input  wire bfie_pkg::mul_ctl_t ctl,
  output logic [63:0]            prod
);
  import bfie_pkg::*;

  logic [31:0] a_lo, a_hi, b_lo, b_hi;
  logic [63:0] lo_prod;

  // Low half product on load, cross terms added on the second step.
  always_ff @(posedge clk) begin
    if (ctl.load) begin
      a_lo    <= ctl.a[31:0];
      a_hi    <= ctl.a[63:32];
      b_lo    <= ctl.b[31:0];
      b_hi    <= ctl.b[63:32];
      lo_prod <= 64'(ctl.a[31:0]) * 64'(ctl.b[31:0]);
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.upper) begin
      prod <= lo_prod + {(a_lo * b_hi) + (a_hi * b_lo), 32'd0};
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/bfie_mod.sv =====
//------------------------------------------------------------------------------
// Bloom filter position reduction
// Reduces a 64-bit hash modulo the filter size by restoring division, one
// quotient bit per cycle.
//------------------------------------------------------------------------------
`default_nettype none

module bfie_mod (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  input  wire logic [63:0] dividend,
  input  wire logic [16:0] divisor,
  output logic             done,
  output logic [16:0]      remainder
);
  import bfie_pkg::*;

  logic [63:0] shreg;
  logic [16:0] rem;
  logic [6:0]  count;
  logic        active;
  logic [17:0] trial;
  logic [17:0] shifted;

  assign shifted = {rem, shreg[63]};
  assign trial   = shifted - {1'b0, divisor};

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
      done   <= 1'b0;
      count  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        active <= 1'b1;
        count  <= 7'd0;
      end else if (active) begin
        count <= count + 7'd1;
        if (count == 7'd63) begin
          active <= 1'b0;
          done   <= 1'b1;
        end
      end
    end
  end

  // One restoring step per cycle; the partial remainder stays below the divisor.
  always_ff @(posedge clk) begin
    if (start) begin
      shreg <= dividend;
      rem   <= '0;
    end else if (active) begin
      shreg <= {shreg[62:0], 1'b0};
      rem   <= trial[17] ? shifted[16:0] : trial[16:0];
    end
  end

  assign remainder = rem;

endmodule

`default_nettype wire

// ===== sim/bfie_checker.sv =====
`timescale 1ns / 1ps
//------------------------------------------------------------------------------
// Bloom filter insert engine checker
// Watches the request, configuration and response channels. It keeps its own
// copy of the filter store and registers, predicts each response and
// compares it with what the engine returns.
//------------------------------------------------------------------------------
`default_nettype none

module bfie_checker
  import bfie_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire logic  start,
  input  wire logic  busy,
  input  wire req_t  req,
  input  wire logic  rsp_valid,
  input  wire rsp_t  rsp,
  input  wire logic  cfg_valid,
  input  wire logic  cfg_ready,
  input  wire logic  cfg_index,
  input  wire logic [31:0] cfg_data,
  output int         fail_count,
  output int         pending
);

  localparam int WORDS = 1024;
  localparam int HASH_CAP = 8;

  logic [63:0] filter_words [WORDS];
  logic [16:0] size_reg;
  logic [3:0]  hashes_reg;
  rsp_t        expected_rsps[$];

  // Finalizer used to spread each hash position.
  function automatic logic [63:0] fmix(input logic [63:0] v);
    logic [63:0] x;
    x = v;
    x = x ^ (x >> 33);
    x = x * MIX_C1;
    x = x ^ (x >> 33);
    x = x * MIX_C2;
    x = x ^ (x >> 33);
    return x;
  endfunction

  // Set the bit of every hash position for one bucket.
  task automatic mark_bucket(input logic [63:0] seed, input logic [63:0] bucket);
    logic [63:0] nbits;
    int          n;
    logic [63:0] m;
    logic [63:0] pos;
    nbits = {47'd0, size_reg};
    if (nbits < 64) nbits = 64;
    if (nbits > WORDS * 64) nbits = WORDS * 64;
    n = (hashes_reg == 4'd0) ? 3 : int'(hashes_reg);
    if (n > HASH_CAP) n = HASH_CAP;
    for (int k = 0; k < n; k++) begin
      m = fmix(seed ^ (64'(k + 1) * GOLDEN) ^ (bucket * BUCKET_MUL));
      pos = m % nbits;
      if ((pos >> 6) < WORDS) filter_words[pos >> 6][pos[5:0]] = 1'b1;
    end
  endtask

  // Apply one request to the store and queue the response it should give.
  task automatic predict_request(input req_t r);
    rsp_t e;
    e = '0;
    if (r.func == FUNC_INSERT) begin
      if (r.key_hash == 0) begin
        e.status = STAT_SKIPPED;
      end else begin
        mark_bucket(r.key_hash, r.time_bucket);
        if (r.also_previous && r.time_bucket != 0)
          mark_bucket(r.key_hash, r.time_bucket - 1);
        e.status = STAT_INSERTED;
      end
    end else if (r.func == FUNC_CLEAR) begin
      for (int i = 0; i < WORDS; i++) filter_words[i] = '0;
      e.status = STAT_CLEARED;
    end else begin
      e.status = STAT_READ;
      e.word_index = r.read_index;
      e.word_value = (r.read_index < WORDS) ? filter_words[r.read_index] : '0;
    end
    expected_rsps.push_back(e);
  endtask

  always @(posedge clk) begin
    rsp_t e;
    if (rst) begin
      for (int i = 0; i < WORDS; i++) filter_words[i] = '0;
      size_reg = 17'd65536;
      hashes_reg = 4'd3;
      expected_rsps.delete();
      fail_count = 0;
    end else begin
      // Compare the response first; a request taken at the same edge
      // cannot have produced it.
      if (rsp_valid) begin
        if (expected_rsps.size() == 0) begin
          $error("unexpected response: status %0d index %0d value %h",
                 rsp.status, rsp.word_index, rsp.word_value);
          fail_count++;
        end else begin
          e = expected_rsps.pop_front();
          if (rsp.status !== e.status) begin
            $error("status: expected %0d, got %0d", e.status, rsp.status);
            fail_count++;
          end
          if (rsp.word_index !== e.word_index) begin
            $error("word_index: expected %0d, got %0d", e.word_index, rsp.word_index);
            fail_count++;
          end
          if (rsp.word_value !== e.word_value) begin
            $error("word_value: expected %h, got %h", e.word_value, rsp.word_value);
            fail_count++;
          end
        end
      end
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == CFG_SIZE) size_reg = cfg_data[16:0];
        else hashes_reg = cfg_data[3:0];
      end
      if (start && !busy) predict_request(req);
    end
    pending = expected_rsps.size();
  end

endmodule

`default_nettype wire

// ===== sim/tb.sv =====
`timescale 1ns / 1ps
//------------------------------------------------------------------------------
// Bloom filter insert engine testbench
// Drives directed and random inserts, reads and clears through several filter
// size and hash count settings, with random gaps between requests. A checker
// beside the engine predicts and compares every response.
//------------------------------------------------------------------------------
`default_nettype none

module tb;
  import bfie_pkg::*;

  localparam logic [1:0] FUNC_SPARE = 2'd3;
  localparam int NUM_PHASES = 8;
  localparam int ITEMS_PER_PHASE = 240;
  localparam int STALL_LIMIT = 20000;

  logic        clk;
  logic        rst;
  logic        start;
  logic        busy;
  req_t        req;
  logic        rsp_valid;
  rsp_t        rsp;
  logic        cfg_valid;
  logic        cfg_ready;
  logic        cfg_index;
  logic [31:0] cfg_data;
  int          fail_count;
  int          pending;
  int          stall_cycles;
  bit          gaps_on;
  int          span_words;

  // Filter size and hash count for each phase, extremes included.
  logic [16:0] phase_size [NUM_PHASES] =
    '{17'd65536, 17'd0, 17'd64, 17'd65, 17'd1000, 17'd131071, 17'd4096, 17'd127};
  logic [3:0]  phase_hashes [NUM_PHASES] =
    '{4'd3, 4'd0, 4'd8, 4'd15, 4'd1, 4'd2, 4'd5, 4'd9};

  bloom_filter_insert_engine u_top (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .req(req),
    .rsp_valid(rsp_valid), .rsp(rsp), .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  bfie_checker u_checker (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .req(req),
    .rsp_valid(rsp_valid), .rsp(rsp), .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .fail_count(fail_count), .pending(pending)
  );

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  // Stop the run when nothing has been accepted for too long.
  always @(posedge clk) begin
    if (rst || (start && !busy) || rsp_valid || (cfg_valid && cfg_ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  // Random filler for the request bus.
  function automatic req_t random_fill();
    logic [191:0] raw;
    raw = {$urandom(), $urandom(), $urandom(), $urandom(), $urandom(), $urandom()};
    return raw[$bits(req_t)-1:0];
  endfunction

  // Send one request, at times after a random burst of idle cycles.
  task automatic send_request(input req_t r);
    if (gaps_on && $urandom_range(0, 3) == 0) begin
      start = 1'b0;
      repeat ($urandom_range(1, 16)) @(negedge clk);
    end
    start = 1'b1;
    req = r;
    do @(posedge clk); while (busy);
    @(negedge clk);
    start = 1'b0;
    req = random_fill();
  endtask

  // Write one register once every response is back.
  task automatic write_register(input logic idx, input logic [16:0] value);
    wait (pending == 0);
    repeat (4) @(negedge clk);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data = {15'($urandom()), value};
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  function automatic req_t make_request(input logic [1:0] f, input logic [63:0] seed,
                                        input logic [63:0] bucket, input logic prev,
                                        input logic [9:0] idx);
    req_t r;
    r = random_fill();
    r.func = f;
    r.key_hash = seed;
    r.time_bucket = bucket;
    r.also_previous = prev;
    r.read_index = idx;
    return r;
  endfunction

  function automatic logic [63:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  // Random request, mostly inserts and reads of words the filter uses.
  function automatic req_t random_request();
    int          pick;
    logic [63:0] seed;
    logic [63:0] bucket;
    logic [9:0]  idx;
    pick = $urandom_range(0, 99);
    case ($urandom_range(0, 9))
      0: seed = '0;
      1: seed = '1;
      default: seed = rand64();
    endcase
    case ($urandom_range(0, 7))
      0: bucket = '0;
      1: bucket = 64'd1;
      2: bucket = '1;
      3: bucket = 64'($urandom_range(0, 1000));
      default: bucket = rand64();
    endcase
    idx = ($urandom_range(0, 4) == 0) ? 10'($urandom())
                                      : 10'($urandom_range(0, span_words - 1));
    if (pick < 55) return make_request(FUNC_INSERT, seed, bucket, 1'($urandom()), idx);
    if (pick < 95) return make_request(FUNC_READ, seed, bucket, 1'($urandom()), idx);
    if (pick < 98) return make_request(FUNC_SPARE, seed, bucket, 1'($urandom()), idx);
    return make_request(FUNC_CLEAR, seed, bucket, 1'($urandom()), idx);
  endfunction

  initial begin
    rst = 1'b1;
    start = 1'b0;
    req = '0;
    cfg_valid = 1'b0;
    cfg_index = CFG_SIZE;
    cfg_data = '0;
    gaps_on = 1'b1;
    span_words = 1024;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed requests under the reset settings.
    send_request(make_request(FUNC_INSERT, '0, 64'd5, 1'b1, 10'd0));
    send_request(make_request(FUNC_INSERT, '1, '1, 1'b1, 10'd1023));
    send_request(make_request(FUNC_INSERT, 64'd1, '0, 1'b1, 10'd0));
    send_request(make_request(FUNC_INSERT, 64'h8000_0000_0000_0000, 64'd1, 1'b1, 10'd0));
    send_request(make_request(FUNC_INSERT, 64'h1234, 64'd7, 1'b0, 10'd0));
    for (int i = 0; i < 4; i++)
      send_request(make_request(FUNC_READ, '0, '0, 1'b0, 10'($urandom())));
    send_request(make_request(FUNC_READ, '0, '0, 1'b0, 10'd0));
    send_request(make_request(FUNC_READ, '0, '0, 1'b0, 10'd1023));
    send_request(make_request(FUNC_SPARE, '1, '1, 1'b1, 10'd1023));
    send_request(make_request(FUNC_CLEAR, '1, '1, 1'b1, 10'd1023));
    send_request(make_request(FUNC_READ, '0, '0, 1'b0, 10'd1023));

    // Random phases, one setting each; the last part runs without gaps.
    for (int p = 0; p < NUM_PHASES; p++) begin
      write_register(CFG_SIZE, phase_size[p]);
      write_register(CFG_HASHES, {13'd0, phase_hashes[p]});
      span_words = (phase_size[p] <= 64) ? 1 :
                   (phase_size[p] >= 65536) ? 1024 : (phase_size[p] + 63) / 64;
      // Each phase: an insert and a read of word zero first.
      send_request(make_request(FUNC_INSERT, rand64(), rand64(), 1'b1, 10'd0));
      send_request(make_request(FUNC_READ, '0, '0, 1'b0, 10'd0));
      for (int i = 0; i < ITEMS_PER_PHASE; i++) begin
        if (p == NUM_PHASES - 1 && i >= ITEMS_PER_PHASE / 3) gaps_on = 1'b0;
        send_request(random_request());
      end
    end

    wait (pending == 0);
    repeat (40) @(posedge clk);
    if (fail_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

`default_nettype wire
